/* rtl/pdst_pkg.sv */
// Shared types and constants for the proper divisor sum / perfect number test.
// No dependencies; the top level and the checker refer to it by scoped names.
`default_nettype none

package pdst_pkg;

    localparam int TOTAL_W = 35;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // result transfer: divisor_total, then perfect_flag, padded to whole bytes
    localparam int FLAG_BIT  = TOTAL_W;
    localparam int M_TDATA_W = ((TOTAL_W + 1 + 7) / 8) * 8;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_DIV   = 6'b000100,
        S_CHECK = 6'b001000,
        S_ADD_Q = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

/* rtl/pdst_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; used by the proper divisor sum top level.
`default_nettype none

module pdst_divider #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [NUM_WIDTH-1:0] dividend,
    input  wire logic [NUM_WIDTH-1:0] divisor,
    output logic                      done,
    output logic [NUM_WIDTH-1:0]      quotient,
    output logic [NUM_WIDTH-1:0]      remainder
);

    localparam int CNT_W = $clog2(NUM_WIDTH);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [NUM_WIDTH-1:0] div_reg, div_next;
    logic [NUM_WIDTH:0]   rem_shift;
    logic [NUM_WIDTH:0]   diff;

    assign rem_shift = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, div_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = CNT_W'(NUM_WIDTH - 1);
            rem_next   = '0;
            quo_next   = dividend;
            div_next   = divisor;
        end else if (busy_reg) begin
            // keep the shifted remainder when the subtract borrows
            if (diff[NUM_WIDTH]) begin
                rem_next = rem_shift[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
            end else begin
                rem_next = diff[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b1};
            end
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/pdst_accum.sv */
// Saturating accumulator for the divisor sum, with a load and a sticky overflow bit.
// Standalone; used by the proper divisor sum top level.
`default_nettype none

module pdst_accum #(
    parameter int ACC_W = 36
) (
    input  wire logic             aclk,
    input  wire logic             load,
    input  wire logic             add_en,
    input  wire logic [ACC_W-1:0] operand,
    output logic [ACC_W-1:0]      acc,
    output logic                  sat
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             sat_reg, sat_next;
    logic [ACC_W:0]   sum;

    assign sum = {1'b0, acc_reg} + {1'b0, operand};

    always_comb begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (load) begin
            acc_next = operand;
            sat_next = 1'b0;
        end else if (add_en) begin
            // pin at all ones on carry out
            if (sum[ACC_W]) begin
                acc_next = {ACC_W{1'b1}};
                sat_next = 1'b1;
            end else begin
                acc_next = sum[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        sat_reg <= sat_next;
    end

    assign acc = acc_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

/* rtl/proper_divisor_sum_perfect_test.sv */
// Proper divisor sum and perfect number test by trial division.
// Depends on pdst_pkg, pdst_divider and pdst_accum.
//
//  channel   direction  tdata fields (low bit up)                      tuser / tlast
//  s_axis    in         number_in[NUM_WIDTH-1:0], zero pad to bytes    none
//  m_axis    out        divisor_total[34:0], perfect_flag[35], pad     none
//
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// Each candidate divisor takes one pass of the bit-serial divider; about
// floor(sqrt(n)) - 1 candidates per item. Inputs at most one, or with the top
// bit set, skip the divisor search and go straight to the result.
// A held result waits in the output register; a new item may start meanwhile.
// Reset is synchronous, active low, and clears the sequencer and output valid.
`default_nettype none

module proper_divisor_sum_perfect_test #(
    parameter int NUM_WIDTH = 32,
    localparam int S_TDATA_W = ((NUM_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]          s_axis_tdata,  // number_in
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [pdst_pkg::M_TDATA_W-1:0]     m_axis_tdata   // divisor_total, perfect_flag
);

    localparam int ACC_W = (NUM_WIDTH + 4 > 64) ? 64 : NUM_WIDTH + 4;

    pdst_pkg::state_t state_reg, state_next;

    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] d_reg, d_next;
    logic                 trivial_reg, trivial_next;
    logic                 m_valid_reg, m_valid_next;
    logic [pdst_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                 in_xfer;
    logic [NUM_WIDTH-1:0] raw;
    logic                 raw_trivial;

    logic                 div_start;
    logic                 div_done;
    logic [NUM_WIDTH-1:0] quo;
    logic [NUM_WIDTH-1:0] rem;

    logic                 acc_load;
    logic                 acc_add;
    logic [NUM_WIDTH-1:0] operand;
    logic [ACC_W-1:0]     acc;
    logic                 acc_sat;

    logic [64:0]                    acc_wide;
    logic [pdst_pkg::TOTAL_W-1:0]   total;
    logic                           perfect;

    assign s_axis_tready = (state_reg == pdst_pkg::S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign raw           = s_axis_tdata[NUM_WIDTH-1:0];
    assign raw_trivial   = raw[NUM_WIDTH-1] || (raw <= NUM_WIDTH'(1));

    assign div_start = (state_reg == pdst_pkg::S_START);

    pdst_divider #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    pdst_accum #(
        .ACC_W (ACC_W)
    ) u_accum (
        .aclk    (aclk),
        .load    (acc_load),
        .add_en  (acc_add),
        .operand (ACC_W'(operand)),
        .acc     (acc),
        .sat     (acc_sat)
    );

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        trivial_next = trivial_reg;
        acc_load     = 1'b0;
        acc_add      = 1'b0;
        operand      = d_reg;
        unique case (state_reg)
            pdst_pkg::S_IDLE: begin
                // seed the sum with 1, or 0 for inputs at most one or with the top bit set
                operand = raw_trivial ? '0 : NUM_WIDTH'(1);
                if (in_xfer) begin
                    acc_load     = 1'b1;
                    n_next       = raw;
                    d_next       = NUM_WIDTH'(2);
                    trivial_next = raw_trivial;
                    state_next   = raw_trivial ? pdst_pkg::S_FIN : pdst_pkg::S_START;
                end
            end
            pdst_pkg::S_START: begin
                state_next = pdst_pkg::S_DIV;
            end
            pdst_pkg::S_DIV: begin
                if (div_done) begin
                    state_next = pdst_pkg::S_CHECK;
                end
            end
            pdst_pkg::S_CHECK: begin
                if (d_reg > quo) begin
                    state_next = pdst_pkg::S_FIN;
                end else if (rem == '0) begin
                    acc_add = 1'b1;
                    if (quo != d_reg) begin
                        state_next = pdst_pkg::S_ADD_Q;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        state_next = pdst_pkg::S_START;
                    end
                end else begin
                    d_next     = d_reg + 1'b1;
                    state_next = pdst_pkg::S_START;
                end
            end
            pdst_pkg::S_ADD_Q: begin
                operand    = quo;
                acc_add    = 1'b1;
                d_next     = d_reg + 1'b1;
                state_next = pdst_pkg::S_START;
            end
            pdst_pkg::S_FIN: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = pdst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pdst_pkg::S_IDLE;
            end
        endcase
    end

    // clamp the reported total; the flag compares against the exact sum
    assign acc_wide = 65'(acc);
    assign total    = (acc_wide > 65'(pdst_pkg::TOTAL_MAX)) ? pdst_pkg::TOTAL_MAX
                                                            : acc_wide[pdst_pkg::TOTAL_W-1:0];
    assign perfect  = !trivial_reg && !acc_sat && (acc == ACC_W'(n_reg));

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == pdst_pkg::S_FIN) && (!m_valid_reg || m_axis_tready)) begin
            m_valid_next = 1'b1;
            m_data_next  = pdst_pkg::M_TDATA_W'({perfect, total});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pdst_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg       <= n_next;
        d_reg       <= d_next;
        trivial_reg <= trivial_next;
        m_data_reg  <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/pdst_checker.sv */
// Port-level checks for proper_divisor_sum_perfect_test, bound to the top level.
// Depends on pdst_pkg for the result layout.
`default_nettype none

module pdst_port_checks (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [pdst_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the block is not ready in the cycle after taking an item
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // the smallest perfect number is 6
    a_flag_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[pdst_pkg::FLAG_BIT]
            |-> m_axis_tdata[pdst_pkg::TOTAL_W-1:0] >= pdst_pkg::TOTAL_W'(6))
        else $error("perfect flag with a total below six");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[pdst_pkg::M_TDATA_W-1:pdst_pkg::FLAG_BIT+1] == '0)
        else $error("pad bits of the result are not zero");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind proper_divisor_sum_perfect_test pdst_port_checks u_pdst_port_checks (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
